// ===== sv/aip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Shared types, character codes, register indexes and clamp limits.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int CHAR_W       = 8;
  localparam int VALUE_W      = 64;
  localparam int BASE_W       = 6;
  localparam int MODE_W       = 2;
  localparam int DIGIT_W      = 6;
  localparam int END_OFFSET_W = 12;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int S_TDATA_W    = 8;
  localparam int M_TDATA_W    = 80;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;

  // Radix codes
  localparam logic [BASE_W-1:0] BASE_DETECT = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;

  // Result modes; any other code is unsigned 64-bit
  localparam logic [MODE_W-1:0] MODE_S32 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S64 = 2'd1;

  // Register indexes (paddr bit 2)
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_RESULT_MODE = 1'b1;

  localparam logic [BASE_W-1:0] NUMBER_BASE_RESET = 6'd10;
  localparam logic [MODE_W-1:0] RESULT_MODE_RESET = 2'd0;

  // Clamp limits
  localparam logic [VALUE_W-1:0] S32_MAX     = 64'h0000_0000_7fff_ffff;
  localparam logic [VALUE_W-1:0] S32_MIN_MAG = 64'h0000_0000_8000_0000;
  localparam logic [VALUE_W-1:0] S32_MIN     = 64'hffff_ffff_8000_0000;
  localparam logic [VALUE_W-1:0] S64_MAX     = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VALUE_W-1:0] S64_MIN_MAG = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] ALL_ONES    = '1;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               digit_valid;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } char_class_t;

  typedef struct packed {
    logic [VALUE_W-1:0]      magnitude;
    logic                    negative;
    logic                    overflowed;
    logic [END_OFFSET_W-1:0] end_offset;
  } raw_result_t;

endpackage : aip_pkg
`default_nettype wire

// ===== sv/aip_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser front end
// Accepts characters and classifies them for the parse engine.
// ----------------------------------------------------------------------------
module aip_front (
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [aip_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
  input  wire logic                           s_tlast,
  input  wire logic                           q_full,
  output logic                                q_push,
  output aip_pkg::char_class_t                q_push_data
);
  import aip_pkg::*;

  logic [CHAR_W-1:0] c;

  assign c        = s_tdata[CHAR_W-1:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_push_data.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    q_push_data.is_plus  = (c == CH_PLUS);
    q_push_data.is_minus = (c == CH_MINUS);
    q_push_data.is_zero  = (c == CH_ZERO);
    q_push_data.is_x     = (c == CH_LOWER_X) || (c == CH_UPPER_X);
    q_push_data.last     = s_tlast;
    q_push_data.digit_valid = 1'b1;
    q_push_data.digit       = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      q_push_data.digit = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      q_push_data.digit = DIGIT_W'(c - CH_LOWER_A + 8'd10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      q_push_data.digit = DIGIT_W'(c - CH_UPPER_A + 8'd10);
    end else begin
      q_push_data.digit_valid = 1'b0;
    end
  end

endmodule : aip_front
`default_nettype wire

// ===== sv/aip_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser queue
// Short FIFO of classified characters between front end and parse engine.
// ----------------------------------------------------------------------------
module aip_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  aip_pkg::char_class_t      push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      pop_valid,
  output aip_pkg::char_class_t      pop_data
);
  import aip_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  char_class_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : aip_queue
`default_nettype wire

// ===== sv/aip_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser engine
// Runs the parse state machine and the digit multiply-add, one character per cycle
// while the result register has room, and registers the raw result of each string.
// ----------------------------------------------------------------------------
module aip_back #(
  parameter int MAX_OFFSET = 4095
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [aip_pkg::BASE_W-1:0]   number_base,
  input  wire logic                         q_valid,
  input  aip_pkg::char_class_t              q_data,
  output logic                              q_pop,
  output logic                              raw_valid,
  output aip_pkg::raw_result_t              raw_data,
  input  wire logic                         raw_ready
);
  import aip_pkg::*;

  localparam int POS_W = $clog2(MAX_OFFSET + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_OFFSET);
  localparam int WIDE_W = VALUE_W + BASE_W;

  phase_t             phase, phase_next;
  logic               is_negative, is_negative_next;
  logic [BASE_W-1:0]  active_base, active_base_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic               overflowed, overflowed_next;
  logic [POS_W-1:0]   char_position, char_position_next;
  logic [POS_W-1:0]   consumed_position, consumed_position_next;

  logic               step;
  logic               at_skip, skip_hold, take_sign, at_signed, zero_prefix;
  logic               take_x, at_digits, digit_ok, stop;
  logic [BASE_W-1:0]  base_eff;
  logic [WIDE_W-1:0]  mac;
  logic               mac_carry;

  // A string's final character waits only for room in the result register.
  assign step  = q_valid && (!q_data.last || !raw_valid || raw_ready);
  assign q_pop = step;

  // Phase decode; a character may fall through several phases in the same cycle.
  always_comb begin
    at_skip     = (phase == PH_SKIP);
    skip_hold   = at_skip && q_data.is_space;
    take_sign   = at_skip && (q_data.is_plus || q_data.is_minus);
    at_signed   = (at_skip && !skip_hold && !take_sign) || (phase == PH_SIGNED);
    zero_prefix = at_signed && q_data.is_zero &&
                  ((number_base == BASE_DETECT) || (number_base == BASE_HEX));
    take_x      = (phase == PH_ZERO) && q_data.is_x;
    at_digits   = (at_signed && !zero_prefix) || ((phase == PH_ZERO) && !q_data.is_x) ||
                  (phase == PH_DIGITS);
    if (at_signed) begin
      base_eff = (number_base == BASE_DETECT) ? BASE_DEC : number_base;
    end else begin
      base_eff = active_base;
    end
    digit_ok  = at_digits && q_data.digit_valid && (q_data.digit < base_eff);
    stop      = at_digits && !digit_ok;
    mac       = WIDE_W'(accumulator) * WIDE_W'(base_eff) + WIDE_W'(q_data.digit);
    mac_carry = |mac[WIDE_W-1:VALUE_W];
  end

  // Next state
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (q_data.last) begin
        phase_next = PH_SKIP;
      end else begin
        unique case (phase)
          PH_SKIP: begin
            if (skip_hold) phase_next = PH_SKIP;
            else if (take_sign) phase_next = PH_SIGNED;
            else if (zero_prefix) phase_next = PH_ZERO;
            else if (stop) phase_next = PH_DONE;
            else phase_next = PH_DIGITS;
          end
          PH_SIGNED: begin
            if (zero_prefix) phase_next = PH_ZERO;
            else if (stop) phase_next = PH_DONE;
            else phase_next = PH_DIGITS;
          end
          PH_ZERO: begin
            if (take_x) phase_next = PH_DIGITS;
            else if (stop) phase_next = PH_DONE;
            else phase_next = PH_DIGITS;
          end
          PH_DIGITS: begin
            phase_next = stop ? PH_DONE : PH_DIGITS;
          end
          PH_DONE: begin
            phase_next = PH_DONE;
          end
          default: begin
            phase_next = PH_SKIP;
          end
        endcase
      end
    end
  end

  // Datapath updates for the character at the head of the queue
  always_comb begin
    is_negative_next = take_sign ? q_data.is_minus : is_negative;

    if (zero_prefix) begin
      active_base_next = (number_base == BASE_DETECT) ? BASE_OCT : BASE_HEX;
    end else if (take_x) begin
      active_base_next = BASE_HEX;
    end else if (at_signed) begin
      active_base_next = base_eff;
    end else begin
      active_base_next = active_base;
    end

    accumulator_next = accumulator;
    overflowed_next  = overflowed;
    if (zero_prefix) begin
      accumulator_next = '0;
    end else if (digit_ok && !overflowed) begin
      if (mac_carry) begin
        accumulator_next = ALL_ONES;
        overflowed_next  = 1'b1;
      end else begin
        accumulator_next = mac[VALUE_W-1:0];
      end
    end

    char_position_next = (char_position < POS_MAX) ? char_position + 1'b1 : POS_MAX;
    consumed_position_next = (zero_prefix || digit_ok) ? char_position_next
                                                       : consumed_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SKIP;
      is_negative       <= 1'b0;
      active_base       <= '0;
      accumulator       <= '0;
      overflowed        <= 1'b0;
      char_position     <= '0;
      consumed_position <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (q_data.last) begin
        is_negative       <= 1'b0;
        active_base       <= '0;
        accumulator       <= '0;
        overflowed        <= 1'b0;
        char_position     <= '0;
        consumed_position <= '0;
      end else begin
        is_negative       <= is_negative_next;
        active_base       <= active_base_next;
        accumulator       <= accumulator_next;
        overflowed        <= overflowed_next;
        char_position     <= char_position_next;
        consumed_position <= consumed_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (step && q_data.last) begin
      raw_valid <= 1'b1;
    end else if (raw_ready) begin
      raw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_data.last) begin
      raw_data.magnitude  <= accumulator_next;
      raw_data.negative   <= is_negative_next;
      raw_data.overflowed <= overflowed_next;
      raw_data.end_offset <= END_OFFSET_W'(consumed_position_next);
    end
  end

endmodule : aip_back
`default_nettype wire

// ===== sv/aip_format.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser result stage
// Applies the sign and the mode clamp, and holds the result for transfer.
// ----------------------------------------------------------------------------
module aip_format (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [aip_pkg::MODE_W-1:0]    result_mode,
  input  wire logic                          raw_valid,
  input  aip_pkg::raw_result_t               raw_data,
  output logic                               raw_ready,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [aip_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                               m_tlast
);
  import aip_pkg::*;

  localparam int PAD_W = M_TDATA_W - VALUE_W - 1 - END_OFFSET_W;

  logic [VALUE_W-1:0]      v;
  logic [VALUE_W-1:0]      r;
  logic [31:0]             neg32;
  logic                    err;
  logic [VALUE_W-1:0]      out_value;
  logic                    out_error;
  logic [END_OFFSET_W-1:0] out_offset;

  assign raw_ready = !m_tvalid || m_tready;

  always_comb begin
    v     = raw_data.magnitude;
    neg32 = 32'd0 - v[31:0];
    err   = raw_data.overflowed;
    case (result_mode)
      MODE_S32: begin
        if (raw_data.negative) begin
          if (v > S32_MIN_MAG) begin
            err = 1'b1;
            r   = S32_MIN;
          end else begin
            r = {{32{neg32[31]}}, neg32};
          end
        end else if (v > S32_MAX) begin
          err = 1'b1;
          r   = S32_MAX;
        end else begin
          r = v;
        end
      end
      MODE_S64: begin
        if (raw_data.negative) begin
          if (v > S64_MIN_MAG) begin
            err = 1'b1;
            r   = S64_MIN_MAG;
          end else begin
            r = '0 - v;
          end
        end else if (v > S64_MAX) begin
          err = 1'b1;
          r   = S64_MAX;
        end else begin
          r = v;
        end
      end
      default: begin
        r = raw_data.negative ? ('0 - v) : v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (raw_valid && raw_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && raw_ready) begin
      out_value  <= r;
      out_error  <= err;
      out_offset <= raw_data.end_offset;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_offset, out_error, out_value};
  assign m_tlast = 1'b1;

endmodule : aip_format
`default_nettype wire

// ===== sv/ascii_integer_parser.sv =====
`default_nettype none
// A character accepted on s_tdata waits in the queue for the parse engine; a string's
// result passes the raw result register and the result stage register to m_tdata.
// Throughput: one character per cycle while results are taken, set by the single
// 64-bit by 6-bit multiply-add in the parse engine; one result per string.
// Reset (rst, synchronous): parse state, queue and result stage clear;
// number_base returns to 10 and result_mode to 0.
// ----------------------------------------------------------------------------
// ASCII integer parser
// Parses one integer per string, one character per transfer, with whitespace
// skip, optional sign, radix prefix detection and range clamping.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int MAX_OFFSET = 4095
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [aip_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] char_code
  input  wire logic                           s_tlast,  // string_end
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [63:0] parsed_value, [64] range_error, [76:65] end_offset, [79:77] zero
  output logic [aip_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast,  // result_last
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [aip_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [aip_pkg::PDATA_W-1:0]    pwdata,
  output logic [aip_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import aip_pkg::*;

  localparam int REG_SEL_BIT = 2;

  logic [BASE_W-1:0] number_base;
  logic [MODE_W-1:0] result_mode;
  logic              cfg_write;

  logic        q_full, q_push, q_pop, q_valid;
  char_class_t q_push_data, q_data;
  logic        raw_valid, raw_ready;
  raw_result_t raw_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= NUMBER_BASE_RESET;
      result_mode <= RESULT_MODE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[REG_SEL_BIT])
        REG_NUMBER_BASE: number_base <= pwdata[BASE_W-1:0];
        REG_RESULT_MODE: result_mode <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_NUMBER_BASE: prdata = PDATA_W'(number_base);
      REG_RESULT_MODE: prdata = PDATA_W'(result_mode);
      default:         prdata = '0;
    endcase
  end

  aip_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  aip_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  aip_back #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .number_base (number_base),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .raw_valid   (raw_valid),
    .raw_data    (raw_data),
    .raw_ready   (raw_ready)
  );

  aip_format u_format (
    .clk         (clk),
    .rst         (rst),
    .result_mode (result_mode),
    .raw_valid   (raw_valid),
    .raw_data    (raw_data),
    .raw_ready   (raw_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule : ascii_integer_parser
`default_nettype wire

// ===== sv/aip_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII integer parser checker
// Port-level assertions on the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module aip_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [aip_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire logic                           m_tlast,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [aip_pkg::PADDR_W-1:0]    paddr,
  input wire logic [aip_pkg::PDATA_W-1:0]    pwdata,
  input wire logic [aip_pkg::PDATA_W-1:0]    prdata,
  input wire logic                           pready
);
  import aip_pkg::*;

  // No result survives a reset.
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result still offered after reset");

  // A stalled result transfer keeps its data.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Every result closes its string and carries zero padding.
  a_result_format: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast && (m_tdata[M_TDATA_W-1:VALUE_W+1+END_OFFSET_W] == '0))
    else $error("result framing or padding wrong");

  // A radix write reads back on the following cycle.
  a_base_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[2] == REG_NUMBER_BASE))
      ##1 (paddr[2] == REG_NUMBER_BASE)
    |-> prdata == PDATA_W'($past(pwdata[BASE_W-1:0])))
    else $error("number_base readback mismatch");

endmodule : aip_checker

bind ascii_integer_parser aip_checker u_aip_checker (.*);
`default_nettype wire

// ===== sim/ascii_integer_parser_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII integer parser checker
// Watches the character stream, the result stream and the register port,
// keeps its own copy of the parse state and the registers, predicts the
// result of every string and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module ascii_integer_parser_check
  import aip_pkg::*;
#(
  parameter int MAX_OFFSET = 4095
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [S_TDATA_W-1:0]    s_tdata,  // [7:0] char_code
  input  logic                    s_tlast,  // string_end
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  // [63:0] parsed_value, [64] range_error, [76:65] end_offset, [79:77] zero
  input  logic [M_TDATA_W-1:0]    m_tdata,
  input  logic                    m_tlast,  // result_last
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  input  logic                    pready,
  output int                      failures,
  output int                      pending
);

  localparam logic [6:0] NO_DIGIT = 7'd64;
  localparam int PAD_LO = VALUE_W + END_OFFSET_W + 1;

  typedef struct packed {
    logic [VALUE_W-1:0]      value;
    logic                    range_err;
    logic [END_OFFSET_W-1:0] offset;
  } parse_result_t;

  parse_result_t           expected_q[$];
  int                      fail_count = 0;

  logic [BASE_W-1:0]       cfg_base;
  logic [MODE_W-1:0]       cfg_mode;

  phase_t                  phase;
  logic                    negative;
  logic [BASE_W-1:0]       radix;
  logic [VALUE_W-1:0]      acc;
  logic                    ovf;
  logic [END_OFFSET_W-1:0] char_pos;
  logic [END_OFFSET_W-1:0] consumed;

  function automatic logic [6:0] char_to_digit(input logic [CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - CH_LOWER_A + 8'd10);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - CH_UPPER_A + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic logic [END_OFFSET_W-1:0] next_pos(input logic [END_OFFSET_W-1:0] p);
    return (p < MAX_OFFSET) ? p + 1'b1 : END_OFFSET_W'(MAX_OFFSET);
  endfunction

  task automatic clear_parse();
    phase    = PH_SKIP;
    negative = 1'b0;
    radix    = '0;
    acc      = '0;
    ovf      = 1'b0;
    char_pos = '0;
    consumed = '0;
  endtask

  // Advances the parse by one character; on the last character of a string
  // the final value is queued and the parse state starts over.
  task automatic predict_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [END_OFFSET_W-1:0] here;
    logic                    taken;
    logic [6:0]              d;
    logic [VALUE_W+5:0]      wide;
    logic [31:0]             low32;
    parse_result_t           res;

    here  = char_pos;
    taken = 1'b0;
    if (phase == PH_SKIP) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
        taken = 1'b1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        negative = (c == CH_MINUS);
        phase    = PH_SIGNED;
        taken    = 1'b1;
      end else begin
        phase = PH_SIGNED;
      end
    end
    if (!taken && phase == PH_SIGNED) begin
      if ((cfg_base == BASE_DETECT || cfg_base == BASE_HEX) && c == CH_ZERO) begin
        radix    = (cfg_base == BASE_DETECT) ? BASE_OCT : BASE_HEX;
        acc      = '0;
        consumed = next_pos(here);
        phase    = PH_ZERO;
        taken    = 1'b1;
      end else begin
        radix = (cfg_base == BASE_DETECT) ? BASE_DEC : cfg_base;
        phase = PH_DIGITS;
      end
    end
    if (!taken && phase == PH_ZERO) begin
      phase = PH_DIGITS;
      if (c == CH_LOWER_X || c == CH_UPPER_X) begin
        radix = BASE_HEX;
        taken = 1'b1;
      end
    end
    if (!taken && phase == PH_DIGITS) begin
      d = char_to_digit(c);
      if (d < {1'b0, radix}) begin
        if (!ovf) begin
          // Any set bit from bit 64 up in the full product means the value no longer fits.
          wide = {6'd0, acc} * radix + d;
          if (|wide[VALUE_W+5:VALUE_W]) begin
            ovf = 1'b1;
            acc = ALL_ONES;
          end else begin
            acc = wide[VALUE_W-1:0];
          end
        end
        consumed = next_pos(here);
      end else begin
        phase = PH_DONE;
      end
    end
    char_pos = next_pos(here);

    if (last) begin
      res.range_err = ovf;
      res.offset    = consumed;
      if (cfg_mode == MODE_S32) begin
        if (negative) begin
          if (acc > S32_MIN_MAG) begin
            res.range_err = 1'b1;
            res.value     = S32_MIN;
          end else begin
            low32     = 32'd0 - acc[31:0];
            res.value = {{32{low32[31]}}, low32};
          end
        end else if (acc > S32_MAX) begin
          res.range_err = 1'b1;
          res.value     = S32_MAX;
        end else begin
          res.value = acc;
        end
      end else if (cfg_mode == MODE_S64) begin
        if (negative) begin
          if (acc > S64_MIN_MAG) begin
            res.range_err = 1'b1;
            res.value     = S64_MIN_MAG;
          end else begin
            res.value = '0 - acc;
          end
        end else if (acc > S64_MAX) begin
          res.range_err = 1'b1;
          res.value     = S64_MAX;
        end else begin
          res.value = acc;
        end
      end else begin
        res.value = negative ? '0 - acc : acc;
      end
      expected_q.push_back(res);
      clear_parse();
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [VALUE_W-1:0] want_v,
                               input logic [VALUE_W-1:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    parse_result_t want;

    if (rst) begin
      cfg_base = NUMBER_BASE_RESET;
      cfg_mode = RESULT_MODE_RESET;
      clear_parse();
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NUMBER_BASE) cfg_base = pwdata[BASE_W-1:0];
        else cfg_mode = pwdata[MODE_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no string pending, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[VALUE_W-1:0] != want.value)
            flag_mismatch("parsed_value", want.value, m_tdata[VALUE_W-1:0]);
          if (m_tdata[VALUE_W] != want.range_err)
            flag_mismatch("range_error", VALUE_W'(want.range_err),
                          VALUE_W'(m_tdata[VALUE_W]));
          if (m_tdata[VALUE_W+END_OFFSET_W:VALUE_W+1] != want.offset)
            flag_mismatch("end_offset", VALUE_W'(want.offset),
                          VALUE_W'(m_tdata[VALUE_W+END_OFFSET_W:VALUE_W+1]));
          if (m_tdata[M_TDATA_W-1:PAD_LO] != '0)
            flag_mismatch("tdata padding", '0, VALUE_W'(m_tdata[M_TDATA_W-1:PAD_LO]));
          if (m_tlast !== 1'b1)
            flag_mismatch("result_last", VALUE_W'(1'b1), VALUE_W'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) predict_char(s_tdata[CHAR_W-1:0], s_tlast);
    end
    pending  <= expected_q.size();
    failures <= fail_count;
  end

endmodule

// ===== sim/ascii_integer_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII integer parser testbench
// Feeds strings one character per transfer: a short directed set covering
// whitespace, signs, radix prefixes, stop characters and odd bases, then
// random well-formed numbers, edge values, overflow runs and noise under a
// range of register settings. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module ascii_integer_parser_test;
  import aip_pkg::*;

  localparam int MAX_OFFSET = 4095;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 13;
  localparam int PHASE_ITEMS = 110;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [MODE_W-1:0] MODE_U64   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;  // [7:0] char_code
  logic                   s_tlast;  // string_end
  logic                   m_tvalid;
  logic                   m_tready;
  // [63:0] parsed_value, [64] range_error, [76:65] end_offset, [79:77] zero
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tlast;  // result_last
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  int                     failures;
  int                     pending;

  logic                   quiet = 1'b0;
  logic                   rush = 1'b0;
  logic                   hold_req = 1'b0;
  logic                   hold_served = 1'b0;
  logic [BASE_W-1:0]      cur_base = NUMBER_BASE_RESET;
  logic [CHAR_W-1:0]      str_buf[$];
  int                     items_sent = 0;

  string limit_strings[10] = '{"0", "2147483647", "2147483648", "2147483649",
                               "4294967295", "9223372036854775807",
                               "9223372036854775808", "9223372036854775809",
                               "18446744073709551615", "18446744073709551616"};

  logic [BASE_W-1:0] fixed_base[8] = '{6'd0, 6'd63, 6'd2, 6'd36, 6'd1, 6'd16, 6'd37, 6'd10};
  logic [MODE_W-1:0] fixed_mode[8] = '{MODE_U64, MODE_S32, MODE_S64, MODE_SPARE,
                                       MODE_U64, MODE_S64, MODE_S32, MODE_U64};

  ascii_integer_parser #(.MAX_OFFSET(MAX_OFFSET)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ascii_integer_parser_check #(.MAX_OFFSET(MAX_OFFSET)) checker_inst (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: short random stalls, one long hold-off on request, none at the end.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    if (!quiet && !rush && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_buf();
    for (int i = 0; i < str_buf.size(); i++) send_char(str_buf[i], i == str_buf.size() - 1);
    str_buf.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_buf();
  endtask

  // Waits until every string has its result and the pipeline has emptied.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits carry junk so that only the register's own bits count.
  task automatic configure(input logic [BASE_W-1:0] base, input logic [MODE_W-1:0] mode);
    logic [PDATA_W-1:0] data;
    drain();
    data = $urandom();
    data[BASE_W-1:0] = base;
    reg_write(REG_NUMBER_BASE, data);
    data = $urandom();
    data[MODE_W-1:0] = mode;
    reg_write(REG_RESULT_MODE, data);
    cur_base = base;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    if ($urandom_range(0, 1)) return CH_LOWER_A + CHAR_W'(v - 10);
    return CH_UPPER_A + CHAR_W'(v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] space_char();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  function automatic int digit_span(input logic [BASE_W-1:0] base);
    if (base == BASE_DETECT) return 10;
    if (base > 36) return 36;
    return base;
  endfunction

  // Mostly well-formed numbers with random content; some noise, some edge values.
  task automatic compose_string(input logic [BASE_W-1:0] base);
    int kind;
    int n;
    int span;

    str_buf.delete();
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      n = $urandom_range(1, 8);
      repeat (n) str_buf.push_back(CHAR_W'($urandom_range(0, 255)));
    end else if (kind < 5 && (base == BASE_DEC || base == BASE_DETECT)) begin
      repeat ($urandom_range(0, 2)) str_buf.push_back(space_char());
      if ($urandom_range(0, 1)) str_buf.push_back(CH_MINUS);
      push_text(limit_strings[$urandom_range(0, 9)]);
    end else begin
      repeat ($urandom_range(0, 3)) str_buf.push_back(space_char());
      case ($urandom_range(0, 3))
        0: str_buf.push_back(CH_PLUS);
        1: str_buf.push_back(CH_MINUS);
        default: ;
      endcase
      span = digit_span(base);
      if (base == BASE_DETECT || base == BASE_HEX || $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            str_buf.push_back(CH_ZERO);
            str_buf.push_back(CH_LOWER_X);
            span = 16;
          end
          1: begin
            str_buf.push_back(CH_ZERO);
            str_buf.push_back(CH_UPPER_X);
            span = 16;
          end
          2: begin
            str_buf.push_back(CH_ZERO);
            if (base == BASE_DETECT) span = 8;
          end
          default: ;
        endcase
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 70) : $urandom_range(0, 6);
      repeat (n) str_buf.push_back(digit_char($urandom_range(0, span - 1)));
      case ($urandom_range(0, 5))
        0: str_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        1: begin
          str_buf.push_back(CH_NUL);
          str_buf.push_back(digit_char($urandom_range(0, span - 1)));
        end
        2: repeat ($urandom_range(1, 4)) str_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        default: ;
      endcase
      if (str_buf.size() == 0) str_buf.push_back(digit_char($urandom_range(0, span - 1)));
    end
  endtask

  initial begin
    int phase_start;
    logic [BASE_W-1:0] base;
    logic [MODE_W-1:0] mode;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed strings; the first ones run on the reset register values.
    send_text(" \t\n-42");
    send_text("+");
    str_buf.push_back(CH_NINE);
    str_buf.push_back(CH_NUL);
    send_text("9");
    push_text("12a");
    str_buf.push_back(8'hFF);
    send_buf();
    configure(BASE_DETECT, MODE_S32);
    send_text("-0x1F");
    send_text("0xg");
    send_text("017");
    send_text("0X");
    configure(BASE_HEX, MODE_S64);
    send_text("0xFf");
    send_text("-ff");
    configure(6'd36, MODE_U64);
    send_text("-Zz");
    send_text("zzzzzzzzzzzzzz9");
    configure(6'd1, MODE_S64);
    send_text("0010");
    configure(6'd63, MODE_SPARE);
    send_text("-zZ9");

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 8) begin
        base = fixed_base[ph];
        mode = fixed_mode[ph];
      end else begin
        case ($urandom_range(0, 7))
          0: base = BASE_DETECT;
          1: base = BASE_HEX;
          2: base = BASE_DEC;
          3: base = BASE_OCT;
          default: base = BASE_W'($urandom_range(0, 63));
        endcase
        mode = MODE_W'($urandom_range(0, 3));
      end
      configure(base, mode);
      if (ph == PHASES - 1) quiet <= 1'b1;

      if (ph == 2) begin
        // Results are held back while short strings keep arriving back to back.
        hold_req <= 1'b1;
        rush     <= 1'b1;
        repeat (200) begin
          repeat ($urandom_range(1, 3))
            str_buf.push_back(digit_char($urandom_range(0, digit_span(cur_base) - 1)));
          send_buf();
        end
        rush <= 1'b0;
        drain();
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        compose_string(cur_base);
        send_buf();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
